// File: rtl/assert_macros.svh
// Assertion macros shared by the codec RTL.
// Depends on a clock named clk_i and an active-low reset named rst_ni in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, ignored while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked on every rising clock edge, ignored while reset is asserted.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication into the following cycle, ignored while reset is asserted.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/scbc_pkg.sv
// Package of the byte-stuffing codec: types, register codes and constants.
// Used by every module of the codec; depends on nothing.
`default_nettype none

package scbc_pkg;

  localparam int unsigned ByteW        = 8;
  localparam int unsigned CfgIndexW    = 3;
  localparam int unsigned QueueDepthDefault = 4;

  localparam logic [ByteW-1:0] XorMask = 8'h20;

  // Reset values of the control characters.
  localparam logic [ByteW-1:0] IdleReset       = 8'hF5;
  localparam logic [ByteW-1:0] EscapeReset     = 8'hFB;
  localparam logic [ByteW-1:0] FlowOnReset     = 8'hFA;
  localparam logic [ByteW-1:0] FlowOffReset    = 8'hFD;
  localparam logic [ByteW-1:0] InactiveReset   = 8'hFF;
  localparam logic [ByteW-1:0] InactiveAltReset = 8'h00;
  localparam logic [ByteW-1:0] LinkReadyReset  = 8'hF3;

  typedef enum logic [CfgIndexW-1:0] {
    REG_IDLE         = 3'd0,
    REG_ESCAPE       = 3'd1,
    REG_FLOW_ON      = 3'd2,
    REG_FLOW_OFF     = 3'd3,
    REG_INACTIVE     = 3'd4,
    REG_INACTIVE_ALT = 3'd5,
    REG_LINK_READY   = 3'd6
  } cfg_reg_e;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } op_e;

  // Current control characters.
  typedef struct packed {
    logic [ByteW-1:0] idle_char;
    logic [ByteW-1:0] escape_char;
    logic [ByteW-1:0] flow_on_char;
    logic [ByteW-1:0] flow_off_char;
    logic [ByteW-1:0] inactive_char;
    logic [ByteW-1:0] inactive_alt_char;
    logic [ByteW-1:0] link_ready_char;
  } cfg_t;

  // One queued job: either a single byte, or an escape byte followed by a data byte.
  typedef struct packed {
    logic             pair;
    logic [ByteW-1:0] esc_byte;
    logic [ByteW-1:0] data_byte;
  } cmd_t;

endpackage

`default_nettype wire

// File: rtl/spi_link_byte_stuffing_codec_top.sv
// Top level of the SPI link byte-stuffing codec (escape plus XOR 0x20).
// Depends on scbc_pkg, scbc_cfg, scbc_front, scbc_queue and scbc_back.
//
//   Channel   Direction  Handshake                      Payload
//   s_axis    in         s_axis_tvalid_i/_tready_o      tdata: data_byte; tuser: op
//   m_axis    out        m_axis_tvalid_o/_tready_i      tdata: out_byte; tlast: last
//   cfg       in         cfg_valid_i/cfg_ready_o        cfg_index_i, cfg_data_i
//
// An input beat is accepted and classified at once; the block takes one input beat per
// cycle while the job queue has room. The output side gives one beat per cycle while
// m_axis_tready_i is high, so an escaped byte holds the output register for both of its
// beats and that output port sets the sustained rate for such bytes. A result is stored
// in the job queue and then in the output register before it is offered. Reset clears
// the escape flag, the queue and the output register, and loads the default control
// characters. A stalled output fills the queue, after which s_axis_tready_o drops;
// configuration writes are always taken.
`default_nettype none

module spi_link_byte_stuffing_codec_top #(
  parameter int unsigned QueueDepth = scbc_pkg::QueueDepthDefault
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Input stream.
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  wire logic [7:0]                      s_axis_tdata_i,  // [7:0] data_byte
  input  wire logic [0:0]                      s_axis_tuser_i,  // [0] op (0 encode, 1 decode)
  // Output stream.
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  output logic [7:0]                           m_axis_tdata_o,  // [7:0] out_byte
  output logic                                 m_axis_tlast_o,
  // Configuration write channel.
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [scbc_pkg::CfgIndexW-1:0]  cfg_index_i,
  input  wire logic [scbc_pkg::ByteW-1:0]      cfg_data_i
);

  scbc_pkg::cfg_t cfg;
  scbc_pkg::cmd_t push_cmd;
  scbc_pkg::cmd_t head_cmd;
  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_empty;

  // Register writes never stall; an index past the last register is dropped.
  assign cfg_ready_o = 1'b1;

  scbc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // The front end keeps the decoder's escape flag and turns every beat into zero or one job.
  scbc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_op_i    (s_axis_tuser_i[0]),
    .in_byte_i  (s_axis_tdata_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (push_cmd)
  );

  scbc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .head_o     (head_cmd),
    .empty_o    (q_empty)
  );

  // The back end expands a job into one or two beats through its output register.
  scbc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (head_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

// File: rtl/scbc_cfg.sv
// Control character register file of the byte-stuffing codec.
// Depends on scbc_pkg.
`default_nettype none

module scbc_cfg (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                wr_en_i,
  input  wire logic [scbc_pkg::CfgIndexW-1:0]      wr_index_i,
  input  wire logic [scbc_pkg::ByteW-1:0]          wr_data_i,
  output scbc_pkg::cfg_t                           cfg_o
);

  scbc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        scbc_pkg::REG_IDLE:         cfg_d.idle_char         = wr_data_i;
        scbc_pkg::REG_ESCAPE:       cfg_d.escape_char       = wr_data_i;
        scbc_pkg::REG_FLOW_ON:      cfg_d.flow_on_char      = wr_data_i;
        scbc_pkg::REG_FLOW_OFF:     cfg_d.flow_off_char     = wr_data_i;
        scbc_pkg::REG_INACTIVE:     cfg_d.inactive_char     = wr_data_i;
        scbc_pkg::REG_INACTIVE_ALT: cfg_d.inactive_alt_char = wr_data_i;
        scbc_pkg::REG_LINK_READY:   cfg_d.link_ready_char   = wr_data_i;
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.idle_char         <= scbc_pkg::IdleReset;
      cfg_q.escape_char       <= scbc_pkg::EscapeReset;
      cfg_q.flow_on_char      <= scbc_pkg::FlowOnReset;
      cfg_q.flow_off_char     <= scbc_pkg::FlowOffReset;
      cfg_q.inactive_char     <= scbc_pkg::InactiveReset;
      cfg_q.inactive_alt_char <= scbc_pkg::InactiveAltReset;
      cfg_q.link_ready_char   <= scbc_pkg::LinkReadyReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: rtl/scbc_front.sv
// Front end of the byte-stuffing codec: accepts input beats and classifies them into jobs.
// Depends on scbc_pkg.
`default_nettype none

module scbc_front (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  scbc_pkg::cfg_t                  cfg_i,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic                       in_op_i,
  input  wire logic [scbc_pkg::ByteW-1:0] in_byte_i,
  input  wire logic                       q_full_i,
  output logic                            q_push_o,
  output scbc_pkg::cmd_t                  q_cmd_o
);

  logic escape_pending_q, escape_pending_d;
  logic accept;
  logic reserved;
  logic emit;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // A byte matching any control character, even several at once, is escaped once.
  assign reserved = (in_byte_i == cfg_i.idle_char)         ||
                    (in_byte_i == cfg_i.escape_char)       ||
                    (in_byte_i == cfg_i.flow_on_char)      ||
                    (in_byte_i == cfg_i.flow_off_char)     ||
                    (in_byte_i == cfg_i.inactive_char)     ||
                    (in_byte_i == cfg_i.inactive_alt_char) ||
                    (in_byte_i == cfg_i.link_ready_char);

  always_comb begin
    escape_pending_d  = escape_pending_q;
    emit              = 1'b0;
    q_cmd_o.pair      = 1'b0;
    q_cmd_o.esc_byte  = cfg_i.escape_char;
    q_cmd_o.data_byte = in_byte_i;
    unique case (in_op_i)
      scbc_pkg::OP_ENCODE: begin
        emit = 1'b1;
        if (reserved) begin
          q_cmd_o.pair      = 1'b1;
          q_cmd_o.data_byte = in_byte_i ^ scbc_pkg::XorMask;
        end
      end
      scbc_pkg::OP_DECODE: begin
        if (escape_pending_q) begin
          // Byte after an escape is unmasked whatever its value.
          escape_pending_d  = 1'b0;
          emit              = 1'b1;
          q_cmd_o.data_byte = in_byte_i ^ scbc_pkg::XorMask;
        end else if (in_byte_i == cfg_i.escape_char) begin
          escape_pending_d = 1'b1;
        end else if (in_byte_i != cfg_i.idle_char) begin
          emit = 1'b1;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign q_push_o = accept && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      escape_pending_q <= 1'b0;
    end else if (accept) begin
      escape_pending_q <= escape_pending_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/scbc_queue.sv
// Short job queue between the front and back ends of the byte-stuffing codec.
// Depends on scbc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module scbc_queue #(
  parameter int unsigned Depth = scbc_pkg::QueueDepthDefault
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  scbc_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  input  wire logic     pop_i,
  output scbc_pkg::cmd_t head_o,
  output logic          empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  scbc_pkg::cmd_t   entries_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  `ASSERT_CLK(a_no_push_full, !(push_i && full_o), "push into a full job queue")
  `ASSERT_CLK(a_no_pop_empty, !(pop_i && empty_o), "pop from an empty job queue")
  `ASSERT_CLK(a_count_range, count_q <= CntW'(Depth), "job queue fill count out of range")

endmodule

`default_nettype wire

// File: rtl/scbc_back.sv
// Back end of the byte-stuffing codec: expands queued jobs into output beats.
// Depends on scbc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module scbc_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       q_empty_i,
  input  scbc_pkg::cmd_t                  q_head_i,
  output logic                            q_pop_o,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [scbc_pkg::ByteW-1:0]      out_byte_o,
  output logic                            out_last_o
);

  logic                       valid_q, valid_d;
  logic [scbc_pkg::ByteW-1:0] byte_q, byte_d;
  logic                       last_q, last_d;
  logic                       pend_q, pend_d;
  logic [scbc_pkg::ByteW-1:0] pend_byte_q, pend_byte_d;
  logic                       slot_free;

  // The output register can take a new beat when it is empty or being drained.
  assign slot_free = !valid_q || out_ready_i;
  assign q_pop_o   = slot_free && !pend_q && !q_empty_i;

  always_comb begin
    valid_d     = valid_q;
    byte_d      = byte_q;
    last_d      = last_q;
    pend_d      = pend_q;
    pend_byte_d = pend_byte_q;
    if (slot_free) begin
      if (pend_q) begin
        valid_d = 1'b1;
        byte_d  = pend_byte_q;
        last_d  = 1'b1;
        pend_d  = 1'b0;
      end else if (!q_empty_i) begin
        valid_d = 1'b1;
        if (q_head_i.pair) begin
          byte_d      = q_head_i.esc_byte;
          last_d      = 1'b0;
          pend_d      = 1'b1;
          pend_byte_d = q_head_i.data_byte;
        end else begin
          byte_d = q_head_i.data_byte;
          last_d = 1'b1;
        end
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q      <= byte_d;
    last_q      <= last_d;
    pend_byte_q <= pend_byte_d;
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;

  `ASSERT_IMPL(a_pend_shows_escape, pend_q, valid_q && !last_q,
               "pending data byte without an escape beat on the output")
  `ASSERT_IMPL(a_escape_has_pend, valid_q && !last_q, pend_q,
               "escape beat on the output without its data byte held")
  `ASSERT_NEXT(a_pair_completes, valid_q && !last_q && out_ready_i, valid_q && last_q,
               "escape beat not followed by the final beat of its pair")

endmodule

`default_nettype wire

// File: tb/tb_spi_link_byte_stuffing_codec_top.sv
// Self-checking testbench for the SPI link byte-stuffing codec top level.
// Depends on scbc_pkg and spi_link_byte_stuffing_codec_top; holds its own codec predictor.
`default_nettype none

module tb_spi_link_byte_stuffing_codec_top;
  import scbc_pkg::*;

  // Index that maps to no control character; a write to it must change nothing.
  localparam logic [CfgIndexW-1:0] RegSpare = 3'd7;
  // The queue plus the output register bound how long a result can lag.
  localparam int unsigned SettleCycles  = QueueDepthDefault + 4;
  localparam int unsigned RxHoldCycles  = 48;
  localparam int unsigned WatchdogLimit = 3000;

  typedef struct packed {
    logic [ByteW-1:0] val;
    logic             last;
  } link_beat_t;

  typedef enum int {
    SET_ALL_ZERO,
    SET_ALL_ONES,
    SET_SPREAD,
    SET_CLASHING,
    SET_DEFAULTS
  } ctrl_set_e;

  logic             clk_i           = 1'b0;
  logic             rst_ni          = 1'b0;
  logic             s_axis_tvalid_i = 1'b0;
  logic             s_axis_tready_o;
  logic [7:0]       s_axis_tdata_i  = 8'h00;  // [7:0] data_byte
  logic [0:0]       s_axis_tuser_i  = 1'b0;   // [0] op
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i = 1'b0;
  logic [7:0]       m_axis_tdata_o;           // [7:0] out_byte
  logic             m_axis_tlast_o;
  logic             cfg_valid_i     = 1'b0;
  logic             cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i = '0;
  logic [ByteW-1:0] cfg_data_i      = '0;

  // Predictor state: the control characters as the block should hold them, and the
  // escape flag of the decoder.
  cfg_t       ctrl_chars;
  logic       esc_armed;
  link_beat_t out_due_q[$];

  int unsigned mismatches  = 0;
  int unsigned idle_cycles = 0;
  int          beat_yield;
  bit          tx_no_gaps  = 1'b0;
  bit          rx_no_gaps  = 1'b0;
  bit          rx_hold_req = 1'b0;
  bit          rx_hold_busy = 1'b0;

  spi_link_byte_stuffing_codec_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ByteW-1:0] ctrl_char_at(int unsigned idx);
    case (idx)
      REG_IDLE:         return ctrl_chars.idle_char;
      REG_ESCAPE:       return ctrl_chars.escape_char;
      REG_FLOW_ON:      return ctrl_chars.flow_on_char;
      REG_FLOW_OFF:     return ctrl_chars.flow_off_char;
      REG_INACTIVE:     return ctrl_chars.inactive_char;
      REG_INACTIVE_ALT: return ctrl_chars.inactive_alt_char;
      default:          return ctrl_chars.link_ready_char;
    endcase
  endfunction

  // True when the byte must be escaped on the way to the link. Coinciding characters
  // still give a single escape.
  function automatic bit ctrl_char_hit(logic [ByteW-1:0] val);
    for (int unsigned i = 0; i < 7; i++) begin
      if (val == ctrl_char_at(i)) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Works out the link or host bytes that one accepted beat must give, queues them and
  // returns how many there are.
  function automatic int predict_codec(op_e op, logic [ByteW-1:0] val);
    if (op == OP_ENCODE) begin
      // Encoding neither reads nor disturbs a pending escape on the decode side.
      if (ctrl_char_hit(val)) begin
        out_due_q.push_back(link_beat_t'{ctrl_chars.escape_char, 1'b0});
        out_due_q.push_back(link_beat_t'{val ^ XorMask, 1'b1});
        return 2;
      end
      out_due_q.push_back(link_beat_t'{val, 1'b1});
      return 1;
    end
    // The byte after an escape is unmasked whatever it is, even another escape.
    if (esc_armed) begin
      esc_armed = 1'b0;
      out_due_q.push_back(link_beat_t'{val ^ XorMask, 1'b1});
      return 1;
    end
    // The escape test comes before the idle test, which matters when they coincide.
    if (val == ctrl_chars.escape_char) begin
      esc_armed = 1'b1;
      return 0;
    end
    if (val == ctrl_chars.idle_char) return 0;
    out_due_q.push_back(link_beat_t'{val, 1'b1});
    return 1;
  endfunction

  function automatic cfg_t pick_ctrl_set(ctrl_set_e kind);
    cfg_t             c;
    logic [ByteW-1:0] pool [3];
    foreach (pool[i]) pool[i] = ByteW'($urandom_range(0, 255));
    case (kind)
      SET_ALL_ZERO: c = '{default: 8'h00};
      SET_ALL_ONES: c = '{default: 8'hFF};
      SET_SPREAD: begin
        c.idle_char         = ByteW'($urandom_range(0, 255));
        c.escape_char       = ByteW'($urandom_range(0, 255));
        c.flow_on_char      = ByteW'($urandom_range(0, 255));
        c.flow_off_char     = ByteW'($urandom_range(0, 255));
        c.inactive_char     = ByteW'($urandom_range(0, 255));
        c.inactive_alt_char = ByteW'($urandom_range(0, 255));
        c.link_ready_char   = ByteW'($urandom_range(0, 255));
      end
      SET_CLASHING: begin
        // Few distinct values, so several characters share one and escape equals idle
        // fairly often.
        c.idle_char         = pool[$urandom_range(0, 2)];
        c.escape_char       = pool[$urandom_range(0, 2)];
        c.flow_on_char      = pool[$urandom_range(0, 2)];
        c.flow_off_char     = pool[$urandom_range(0, 2)];
        c.inactive_char     = pool[$urandom_range(0, 2)];
        c.inactive_alt_char = pool[$urandom_range(0, 2)];
        c.link_ready_char   = pool[$urandom_range(0, 2)];
      end
      default: begin
        c.idle_char         = IdleReset;
        c.escape_char       = EscapeReset;
        c.flow_on_char      = FlowOnReset;
        c.flow_off_char     = FlowOffReset;
        c.inactive_char     = InactiveReset;
        c.inactive_alt_char = InactiveAltReset;
        c.link_ready_char   = LinkReadyReset;
      end
    endcase
    return c;
  endfunction

  // Biased towards the control characters and their masked forms, so that escapes,
  // idles and collisions turn up often.
  function automatic logic [ByteW-1:0] pick_link_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return ctrl_char_at($urandom_range(0, 6));
    if (r < 45) return ctrl_char_at($urandom_range(0, 6)) ^ XorMask;
    if (r < 50) return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
    return ByteW'($urandom_range(0, 255));
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch on %s: got %h, want %h", what, got, want);
    mismatches++;
  endtask

  // Offers one beat after a random gap and predicts its results once it is taken. The
  // valid stays high on return, so that a following beat with no gap needs no second
  // assignment in the same step.
  task automatic send_codec_beat(input op_e op, input logic [ByteW-1:0] val);
    int unsigned gap;
    gap = tx_no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= val;
    s_axis_tuser_i  <= op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    beat_yield = predict_codec(op, val);
  endtask

  // A register write updates the predictor once the block has taken it; an index past
  // the last register is dropped by both.
  task automatic write_ctrl_reg(input logic [CfgIndexW-1:0] idx, input logic [ByteW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_IDLE:         ctrl_chars.idle_char         = val;
      REG_ESCAPE:       ctrl_chars.escape_char       = val;
      REG_FLOW_ON:      ctrl_chars.flow_on_char      = val;
      REG_FLOW_OFF:     ctrl_chars.flow_off_char     = val;
      REG_INACTIVE:     ctrl_chars.inactive_char     = val;
      REG_INACTIVE_ALT: ctrl_chars.inactive_alt_char = val;
      REG_LINK_READY:   ctrl_chars.link_ready_char   = val;
      default: ;
    endcase
  endtask

  task automatic cfg_quiet();
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_ctrl_chars(input cfg_t c);
    write_ctrl_reg(REG_IDLE,         c.idle_char);
    write_ctrl_reg(REG_ESCAPE,       c.escape_char);
    write_ctrl_reg(REG_FLOW_ON,      c.flow_on_char);
    write_ctrl_reg(REG_FLOW_OFF,     c.flow_off_char);
    write_ctrl_reg(REG_INACTIVE,     c.inactive_char);
    write_ctrl_reg(REG_INACTIVE_ALT, c.inactive_alt_char);
    write_ctrl_reg(REG_LINK_READY,   c.link_ready_char);
    cfg_quiet();
  endtask

  // Stops offering beats, waits for every predicted result and then lets the block
  // finish any beat that gives nothing, so that it is idle afterwards.
  task automatic wait_link_quiet();
    s_axis_tvalid_i <= 1'b0;
    while (out_due_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Every reset control character, 00 and FF among them, is escaped once; plain bytes,
  // some next to them, go straight through.
  task automatic test_encode_reset_chars();
    logic [ByteW-1:0] plain [5] = '{8'h01, 8'h7F, 8'h80, 8'hFE, 8'hDB};
    for (int unsigned i = 0; i < 7; i++) send_codec_beat(OP_ENCODE, ctrl_char_at(i));
    foreach (plain[i]) send_codec_beat(OP_ENCODE, plain[i]);
  endtask

  // Decoding at the reset characters: plain bytes, idle dropped, escape pairs, an escape
  // followed by another escape or by idle, and an escape that survives an encode beat.
  task automatic test_decode_escapes();
    send_codec_beat(OP_DECODE, 8'h41);
    send_codec_beat(OP_DECODE, IdleReset);
    send_codec_beat(OP_DECODE, EscapeReset);
    send_codec_beat(OP_DECODE, EscapeReset ^ XorMask);
    send_codec_beat(OP_DECODE, EscapeReset);
    send_codec_beat(OP_DECODE, EscapeReset);
    send_codec_beat(OP_DECODE, EscapeReset);
    send_codec_beat(OP_ENCODE, 8'h10);
    send_codec_beat(OP_DECODE, 8'h00);
    send_codec_beat(OP_DECODE, EscapeReset);
    send_codec_beat(OP_DECODE, IdleReset);
    send_codec_beat(OP_DECODE, 8'hFF);
    send_codec_beat(OP_DECODE, 8'h00);
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering escaped
  // bytes with no gaps, so the queue fills and the input must stall.
  task automatic test_backpressure();
    wait_link_quiet();
    rx_hold_req = 1'b1;
    while (!rx_hold_busy) @(posedge clk_i);
    tx_no_gaps = 1'b1;
    for (int unsigned i = 0; i < 24; i++) send_codec_beat(OP_ENCODE, ctrl_char_at(i % 7));
    tx_no_gaps = 1'b0;
    // The sender now pauses until the whole backlog has drained.
    wait_link_quiet();
  endtask

  // A write to the spare index is dropped; then every character takes one value, so a
  // byte equal to it is escaped once and on decode counts as an escape, not as idle.
  task automatic test_coinciding_chars();
    wait_link_quiet();
    write_ctrl_reg(RegSpare, 8'h41);
    cfg_quiet();
    send_codec_beat(OP_ENCODE, 8'h41);
    wait_link_quiet();
    load_ctrl_chars('{default: 8'h7E});
    send_codec_beat(OP_ENCODE, 8'h7E);
    send_codec_beat(OP_DECODE, 8'h7E);
    send_codec_beat(OP_DECODE, 8'h7E);
    send_codec_beat(OP_DECODE, 8'h7E);
    send_codec_beat(OP_DECODE, 8'h00);
    send_codec_beat(OP_DECODE, 8'h55);
  endtask

  // Phases of random traffic, each under its own set of control characters, extremes
  // included. Most decode traffic is escape pairs with random content; the rest is
  // loose bytes, which leave lone escapes and idles behind. Part of every phase runs
  // without gaps on either side.
  task automatic test_random_traffic();
    int unsigned phase, taken, r;
    ctrl_set_e   kind;
    for (phase = 0; phase < 8; phase++) begin
      wait_link_quiet();
      kind = (phase < 5) ? ctrl_set_e'(phase) : (($urandom_range(0, 1) != 0) ? SET_SPREAD
                                                                            : SET_CLASHING);
      load_ctrl_chars(pick_ctrl_set(kind));
      taken = 0;
      while (taken < 140) begin
        tx_no_gaps = (taken >= 80 && taken < 120);
        rx_no_gaps = tx_no_gaps;
        r = $urandom_range(0, 99);
        if (r < 35) begin
          send_codec_beat(OP_ENCODE, pick_link_byte());
        end else if (r < 70) begin
          send_codec_beat(OP_DECODE, ctrl_chars.escape_char);
          taken += (beat_yield > 0);
          send_codec_beat(OP_DECODE, pick_link_byte());
        end else begin
          send_codec_beat(OP_DECODE, pick_link_byte());
        end
        taken += (beat_yield > 0);
      end
    end
    tx_no_gaps = 1'b0;
    rx_no_gaps = 1'b0;
  endtask

  // Receiver: random stalls, or one long hold-off when the back-pressure test asks.
  initial begin
    int unsigned gap;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (rx_hold_req) begin
        rx_hold_busy = 1'b1;
        m_axis_tready_i <= 1'b0;
        repeat (RxHoldCycles) @(posedge clk_i);
        rx_hold_req  = 1'b0;
        rx_hold_busy = 1'b0;
      end else begin
        gap = rx_no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
          m_axis_tready_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      m_axis_tready_i <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  // Every result beat is held against the oldest prediction, field by field.
  always @(posedge clk_i) begin
    link_beat_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (out_due_q.size() == 0) begin
        report_mismatch("unexpected beat", m_axis_tdata_o, 8'h00);
      end else begin
        want = out_due_q.pop_front();
        if (m_axis_tdata_o !== want.val) report_mismatch("out_byte", m_axis_tdata_o, want.val);
        if (m_axis_tlast_o !== want.last) begin
          report_mismatch("last", {7'b0, m_axis_tlast_o}, {7'b0, want.last});
        end
      end
    end
  end

  // Ends the run when no channel has moved a beat for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i) || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    ctrl_chars = pick_ctrl_set(SET_DEFAULTS);
    esc_armed  = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_encode_reset_chars();
    test_decode_escapes();
    test_backpressure();
    test_coinciding_chars();
    test_random_traffic();

    wait_link_quiet();
    if (mismatches == 0 && out_due_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
